>>> rtl/assert_macros.svh
// Assertion macros used by the RTL of the rational fraction ALU.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rfa_pkg.sv
// Package with the types, codes and helpers of the rational fraction ALU.
package rfa_pkg;

  localparam int WORD_BITS = 32;
  localparam int CNT_BITS  = $clog2(WORD_BITS);

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [2:0] {
    K_ADD  = 3'd0,
    K_SUB  = 3'd1,
    K_MUL  = 3'd2,
    K_DIV  = 3'd3,
    K_CMP  = 3'd4,
    K_SIMP = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_FIN,
    S_EUC,
    S_DIV,
    S_DIVEND,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_REM,
    PH_QN,
    PH_QD
  } phase_t;

  // Magnitude of a two's complement word, as an unsigned word.
  function automatic word_t mag(input word_t x);
    mag = x[WORD_BITS-1] ? word_t'(-x) : x;
  endfunction

endpackage

>>> rtl/rational_fraction_alu.sv
// Rational fraction ALU: one shared multiplier and one shared serial divider.
//
//  channel  direction  signals
//  req      in         req_valid, req_stall, kind, a_num, a_den, b_num, b_den
//  res      out        res_valid, res_stall, res_num, res_den, gcd_zero
//
// Add, sub, mul, div and compare form three products through the one multiplier
// in S_MUL, then S_FIN forms the result. Simplify runs Euclid on the shared
// divider, one serial division per remainder step (steps <= 46), then two
// quotient divisions. Unused codes go to S_DONE with a zero result. Reset is
// synchronous and clears the sequencer and the result valid; one item is in
// work at a time, and a stalled result holds the sequencer in its done state
// until the result slot frees.
`include "assert_macros.svh"

module rational_fraction_alu (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [2:0]                  kind,
  input  logic signed [31:0]          a_num,
  input  logic signed [31:0]          a_den,
  input  logic signed [31:0]          b_num,
  input  logic signed [31:0]          b_den,
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic signed [31:0]          res_num,
  output logic signed [31:0]          res_den,
  output logic                        gcd_zero
);
  import rfa_pkg::*;

  state_t              state, state_next;
  phase_t              phase, phase_next;
  logic [1:0]          mstep, mstep_next;
  logic [2:0]          op, op_next;
  word_t               an, an_next, ad, ad_next, bn, bn_next, bd, bd_next;
  word_t               p0, p0_next, p1, p1_next, p2, p2_next;
  word_t               ea, ea_next, eb, eb_next, g, g_next;
  word_t               rn, rn_next, rd, rd_next;
  logic                gz, gz_next;
  word_t               dvd, dvd_next, rem, rem_next, dvs, dvs_next;
  logic [CNT_BITS-1:0] dcnt, dcnt_next;
  logic                res_valid_next;
  word_t               res_num_next, res_den_next;
  logic                gcd_zero_next;
  logic                load_res;

  word_t               mx, my, mprod;
  logic [WORD_BITS:0]  shifted, diff;

  assign req_stall = (state != S_IDLE);

  // Operand selection for the shared multiplier.
  always_comb begin
    mx = an;
    my = bd;
    case (mstep)
      2'd0: begin
        mx = an;
        my = (op == K_MUL) ? bn : bd;
      end
      2'd1: begin
        mx = ad;
        my = (op == K_MUL) ? bd : bn;
      end
      default: begin
        mx = ad;
        my = bd;
      end
    endcase
  end

  assign mprod = word_t'(mx * my);

  // One restoring division step.
  assign shifted = {rem, dvd[WORD_BITS-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_comb begin
    state_next     = state;
    phase_next     = phase;
    mstep_next     = mstep;
    op_next        = op;
    an_next        = an;
    ad_next        = ad;
    bn_next        = bn;
    bd_next        = bd;
    p0_next        = p0;
    p1_next        = p1;
    p2_next        = p2;
    ea_next        = ea;
    eb_next        = eb;
    g_next         = g;
    rn_next        = rn;
    rd_next        = rd;
    gz_next        = gz;
    dvd_next       = dvd;
    rem_next       = rem;
    dvs_next       = dvs;
    dcnt_next      = dcnt;
    res_num_next   = res_num;
    res_den_next   = res_den;
    gcd_zero_next  = gcd_zero;
    load_res       = 1'b0;
    res_valid_next = res_valid && res_stall;

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          op_next    = kind;
          an_next    = a_num;
          ad_next    = a_den;
          bn_next    = b_num;
          bd_next    = b_den;
          gz_next    = 1'b0;
          mstep_next = 2'd0;
          case (kind)
            K_ADD, K_SUB, K_MUL, K_DIV, K_CMP: begin
              state_next = S_MUL;
            end
            K_SIMP: begin
              ea_next    = a_num;
              eb_next    = a_den;
              state_next = S_EUC;
            end
            default: begin
              rn_next    = '0;
              rd_next    = '0;
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_MUL: begin
        case (mstep)
          2'd0:    p0_next = mprod;
          2'd1:    p1_next = mprod;
          default: p2_next = mprod;
        endcase
        mstep_next = mstep + 2'd1;
        if (mstep == 2'd2) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        case (op)
          K_ADD: begin
            rn_next = p0 + p1;
            rd_next = p2;
          end
          K_SUB: begin
            rn_next = p0 - p1;
            rd_next = p2;
          end
          K_CMP: begin
            rn_next = p0 - p1;
            rd_next = '0;
          end
          default: begin
            rn_next = p0;
            rd_next = (op == K_MUL) ? p2 : p1;
          end
        endcase
        state_next = S_DONE;
      end
      S_EUC: begin
        dcnt_next = '0;
        rem_next  = '0;
        if (eb == '0) begin
          if (ea == '0) begin
            rn_next    = an;
            rd_next    = ad;
            gz_next    = 1'b1;
            state_next = S_DONE;
          end else begin
            g_next     = ea;
            dvd_next   = mag(an);
            dvs_next   = mag(ea);
            phase_next = PH_QN;
            state_next = S_DIV;
          end
        end else begin
          dvd_next   = mag(ea);
          dvs_next   = mag(eb);
          phase_next = PH_REM;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (!diff[WORD_BITS]) begin
          rem_next = diff[WORD_BITS-1:0];
          dvd_next = {dvd[WORD_BITS-2:0], 1'b1};
        end else begin
          rem_next = shifted[WORD_BITS-1:0];
          dvd_next = {dvd[WORD_BITS-2:0], 1'b0};
        end
        dcnt_next = dcnt + 1'b1;
        if (dcnt == CNT_BITS'(WORD_BITS - 1)) begin
          state_next = S_DIVEND;
        end
      end
      S_DIVEND: begin
        dcnt_next = '0;
        rem_next  = '0;
        case (phase)
          PH_REM: begin
            // The remainder takes the sign of the dividend.
            ea_next    = eb;
            eb_next    = ea[WORD_BITS-1] ? word_t'(-rem) : rem;
            state_next = S_EUC;
          end
          PH_QN: begin
            rn_next    = (an[WORD_BITS-1] ^ g[WORD_BITS-1]) ? word_t'(-dvd) : dvd;
            dvd_next   = mag(ad);
            dvs_next   = mag(g);
            phase_next = PH_QD;
            state_next = S_DIV;
          end
          default: begin
            rd_next    = (ad[WORD_BITS-1] ^ g[WORD_BITS-1]) ? word_t'(-dvd) : dvd;
            state_next = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        if (!res_valid || !res_stall) begin
          load_res       = 1'b1;
          res_valid_next = 1'b1;
          res_num_next   = rn;
          res_den_next   = rd;
          gcd_zero_next  = gz;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    phase    <= phase_next;
    mstep    <= mstep_next;
    op       <= op_next;
    an       <= an_next;
    ad       <= ad_next;
    bn       <= bn_next;
    bd       <= bd_next;
    p0       <= p0_next;
    p1       <= p1_next;
    p2       <= p2_next;
    ea       <= ea_next;
    eb       <= eb_next;
    g        <= g_next;
    rn       <= rn_next;
    rd       <= rd_next;
    gz       <= gz_next;
    dvd      <= dvd_next;
    rem      <= rem_next;
    dvs      <= dvs_next;
    dcnt     <= dcnt_next;
    res_num  <= res_num_next;
    res_den  <= res_den_next;
    gcd_zero <= gcd_zero_next;
  end

  // A zero gcd only arises from a zero over zero input, which passes through.
  `ASSERT_SAME(a_gz_zero, clk, rst, res_valid && gcd_zero, (res_num == 0) && (res_den == 0), "gcd_zero with nonzero fraction")
  // The shared divider never runs with a zero divisor.
  `ASSERT_SAME(a_div_nz, clk, rst, state == S_DIV, dvs != '0, "division by zero in shared divider")
  // The partial remainder stays below the divisor.
  `ASSERT_SAME(a_rem_lt, clk, rst, state == S_DIV, rem < dvs, "partial remainder not below divisor")
  // A compare result always carries a zero denominator.
  `ASSERT_NEXT(a_cmp_den, clk, rst, load_res && (op == K_CMP), res_valid && (res_den == 0), "compare result with nonzero denominator")

endmodule
